/* design/sfsl_pkg.sv */
package sfsl_pkg;

  // item modes
  localparam logic [2:0] MODE_WRITE   = 3'd0;
  localparam logic [2:0] MODE_TICK    = 3'd1;
  localparam logic [2:0] MODE_ENABLE  = 3'd2;
  localparam logic [2:0] MODE_DISABLE = 3'd3;
  localparam logic [2:0] MODE_RESET   = 3'd4;
  localparam logic [2:0] MODE_READ    = 3'd5;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // current write data select
  localparam logic [1:0] CUR_ZERO   = 2'd0;
  localparam logic [1:0] CUR_TARGET = 2'd1;
  localparam logic [1:0] CUR_STEP   = 2'd2;

  // quotient bits of the scaled step, one per divider cycle
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic       cur_we;
    logic [1:0] cur_sel;
    logic       tgt_we;
    logic       tgt_load;
    logic       max_clr;
    logic       max_acc;
    logic       nz_clr;
    logic       nz_acc;
    logic       mul_go;
    logic       div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic over_rate;
    logic all_near_zero;
  } dp_stat_t;

  // lowest bit first: is_enabled, is_disabling, read_value, stepped, disable_done, status
  typedef struct packed {
    logic        status;
    logic        disable_done;
    logic        stepped;
    logic [31:0] read_value;
    logic        is_disabling;
    logic        is_enabled;
  } result_t;

endpackage

/* design/sfsl_dpath.sv */
module sfsl_dpath import sfsl_pkg::*; #(
  parameter int Depth = 268,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [31:0]      value_i,
  input  logic [30:0]      max_rate_i,
  input  logic [30:0]      near_zero_i,
  output dp_stat_t         stat_o,
  output logic [31:0]      cur_o
);

  logic [31:0] cur_mem [Depth];
  logic [31:0] tgt_mem [Depth];
  logic [31:0] cur_rd_q, tgt_rd_q;
  logic [31:0] cur_wdata;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic signed [32:0] c33, nz33;
  logic               near;
  logic [62:0]        prod_lo;
  logic [63:0]        prod;

  logic [32:0] largest_q;
  logic        nz_ok_q;
  logic [32:0] rem_q;
  logic [30:0] quo_q;
  logic        neg_q;
  logic [31:0] hold_q;
  logic [33:0] trial;
  logic        fits;
  logic [31:0] mv;

  // force stores, registered read at the shared address
  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_we) cur_mem[addr_i] <= cur_wdata;
    if (cmd_i.tgt_we) tgt_mem[addr_i] <= cmd_i.tgt_load ? value_i : 32'd0;
    cur_rd_q <= cur_mem[addr_i];
    tgt_rd_q <= tgt_mem[addr_i];
  end

  // full-width difference and magnitude
  assign diff = $signed({tgt_rd_q[31], tgt_rd_q}) - $signed({cur_rd_q[31], cur_rd_q});
  assign mag  = diff[32] ? (~diff + 33'sd1) : diff;

  // strict window around zero
  assign c33  = $signed({cur_rd_q[31], cur_rd_q});
  assign nz33 = $signed({2'b00, near_zero_i});
  assign near = (c33 < nz33) && (c33 > -nz33);

  // magnitude times rate; the magnitude only reaches bit 32 when the low word is zero
  assign prod_lo = mag[31:0] * max_rate_i;
  assign prod    = mag[32] ? {1'b0, max_rate_i, 32'd0} : {1'b0, prod_lo};

  // restoring divider by the largest magnitude
  assign trial = {rem_q, quo_q[30]};
  assign fits  = trial >= {1'b0, largest_q};
  assign mv    = neg_q ? (32'd0 - {1'b0, quo_q}) : {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q <= '0;
      nz_ok_q   <= 1'b1;
    end else begin
      if (cmd_i.max_clr) largest_q <= '0;
      else if (cmd_i.max_acc && (mag > largest_q)) largest_q <= mag;
      if (cmd_i.nz_clr) nz_ok_q <= 1'b1;
      else if (cmd_i.nz_acc) nz_ok_q <= nz_ok_q & near;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      rem_q  <= prod[63:31];
      quo_q  <= prod[30:0];
      neg_q  <= diff[32];
      hold_q <= cur_rd_q;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 33'(trial - {1'b0, largest_q}) : trial[32:0];
      quo_q <= {quo_q[29:0], fits};
    end
  end

  // current write data
  always_comb begin
    case (cmd_i.cur_sel)
      CUR_ZERO:   cur_wdata = 32'd0;
      CUR_TARGET: cur_wdata = tgt_rd_q;
      CUR_STEP:   cur_wdata = hold_q + mv;
      default:    cur_wdata = 32'd0;
    endcase
  end

  assign stat_o.over_rate     = largest_q > {2'b00, max_rate_i};
  assign stat_o.all_near_zero = nz_ok_q;
  assign cur_o                = cur_rd_q;

endmodule

/* design/sfsl_ctrl.sv */
module sfsl_ctrl import sfsl_pkg::*; #(
  parameter int XCh   = 12,
  parameter int YCh   = 100,
  parameter int ZCh   = 156,
  parameter int Depth = XCh + YCh + ZCh,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       mode_i,
  input  logic [1:0]       axis_i,
  input  logic [7:0]       channel_i,
  input  logic [31:0]      value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_o,
  output dp_cmd_t          cmd_o,
  output logic [AddrW-1:0] addr_o,
  output logic [31:0]      value_o,
  input  dp_stat_t         stat_i,
  input  logic [31:0]      cur_i
);

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CLR  = 5'd2;
  localparam logic [4:0] S_ZRD  = 5'd3;
  localparam logic [4:0] S_ZACC = 5'd4;
  localparam logic [4:0] S_ZDEC = 5'd5;
  localparam logic [4:0] S_MRD  = 5'd6;
  localparam logic [4:0] S_MACC = 5'd7;
  localparam logic [4:0] S_MDEC = 5'd8;
  localparam logic [4:0] S_VRD  = 5'd9;
  localparam logic [4:0] S_VMUL = 5'd10;
  localparam logic [4:0] S_VDIV = 5'd11;
  localparam logic [4:0] S_VWR  = 5'd12;
  localparam logic [4:0] S_SRD  = 5'd13;
  localparam logic [4:0] S_SWR  = 5'd14;
  localparam logic [4:0] S_WRT  = 5'd15;
  localparam logic [4:0] S_RDA  = 5'd16;
  localparam logic [4:0] S_RDC  = 5'd17;
  localparam logic [4:0] S_RES  = 5'd18;

  localparam logic [AddrW-1:0] LAST = AddrW'(Depth - 1);

  logic [4:0]       state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             en_q, en_d, dis_q, dis_d;
  logic             clr_cur_q, clr_cur_d, clr_tgt_q, clr_tgt_d;
  logic [31:0]      value_q, value_d;
  logic             stepped_q, stepped_d, done_q, done_d, bad_q, bad_d;
  logic [31:0]      rdv_q, rdv_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic [9:0]       idx_wide;
  logic             idx_ok;
  logic             last;

  // flat channel index of the request
  always_comb begin
    idx_ok   = 1'b0;
    idx_wide = 10'd0;
    case (axis_i)
      AXIS_X: begin
        idx_ok   = {1'b0, channel_i} < 9'(XCh);
        idx_wide = 10'(channel_i);
      end
      AXIS_Y: begin
        idx_ok   = {1'b0, channel_i} < 9'(YCh);
        idx_wide = 10'(XCh) + 10'(channel_i);
      end
      AXIS_Z: begin
        idx_ok   = {1'b0, channel_i} < 9'(ZCh);
        idx_wide = 10'(XCh + YCh) + 10'(channel_i);
      end
      default: idx_ok = 1'b0;
    endcase
  end

  assign last = addr_q == LAST;

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    en_d        = en_q;
    dis_d       = dis_q;
    clr_cur_d   = clr_cur_q;
    clr_tgt_d   = clr_tgt_q;
    value_d     = value_q;
    stepped_d   = stepped_q;
    done_d      = done_q;
    bad_d       = bad_q;
    rdv_d       = rdv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.cur_we = 1'b1;
        cmd_o.tgt_we = 1'b1;
        if (last) state_d = S_IDLE;
        else addr_d = addr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          stepped_d = 1'b0;
          done_d    = 1'b0;
          bad_d     = 1'b0;
          rdv_d     = 32'd0;
          value_d   = value_i;
          addr_d    = '0;
          state_d   = S_RES;
          case (mode_i)
            MODE_WRITE, MODE_READ: begin
              if (idx_ok) begin
                addr_d  = idx_wide[AddrW-1:0];
                state_d = (mode_i == MODE_WRITE) ? S_WRT : S_RDA;
              end else begin
                bad_d = 1'b1;
              end
            end
            MODE_TICK: begin
              if (dis_q) begin
                cmd_o.nz_clr = 1'b1;
                state_d      = S_ZRD;
              end else if (en_q) begin
                cmd_o.max_clr = 1'b1;
                stepped_d     = 1'b1;
                state_d       = S_MRD;
              end
            end
            MODE_ENABLE, MODE_DISABLE: begin
              en_d      = (mode_i == MODE_ENABLE);
              dis_d     = (mode_i == MODE_DISABLE);
              clr_cur_d = 1'b0;
              clr_tgt_d = 1'b1;
              state_d   = S_CLR;
            end
            MODE_RESET: begin
              en_d      = 1'b0;
              dis_d     = 1'b0;
              clr_cur_d = 1'b1;
              clr_tgt_d = 1'b1;
              state_d   = S_CLR;
            end
            default: state_d = S_RES;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.cur_we = clr_cur_q;
        cmd_o.tgt_we = clr_tgt_q;
        if (last) state_d = S_RES;
        else addr_d = addr_q + 1'b1;
      end
      S_ZRD: state_d = S_ZACC;
      S_ZACC: begin
        cmd_o.nz_acc = 1'b1;
        if (last) state_d = S_ZDEC;
        else begin
          addr_d  = addr_q + 1'b1;
          state_d = S_ZRD;
        end
      end
      S_ZDEC: begin
        addr_d = '0;
        if (stat_i.all_near_zero) begin
          en_d      = 1'b0;
          dis_d     = 1'b0;
          done_d    = 1'b1;
          clr_cur_d = 1'b1;
          clr_tgt_d = 1'b0;
          state_d   = S_CLR;
        end else begin
          cmd_o.max_clr = 1'b1;
          stepped_d     = 1'b1;
          state_d       = S_MRD;
        end
      end
      S_MRD: state_d = S_MACC;
      S_MACC: begin
        cmd_o.max_acc = 1'b1;
        if (last) state_d = S_MDEC;
        else begin
          addr_d  = addr_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_MDEC: begin
        addr_d  = '0;
        state_d = stat_i.over_rate ? S_VRD : S_SRD;
      end
      S_VRD: state_d = S_VMUL;
      S_VMUL: begin
        cmd_o.mul_go = 1'b1;
        cnt_d        = 5'd0;
        state_d      = S_VDIV;
      end
      S_VDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) state_d = S_VWR;
      end
      S_VWR: begin
        cmd_o.cur_we  = 1'b1;
        cmd_o.cur_sel = CUR_STEP;
        if (last) state_d = S_RES;
        else begin
          addr_d  = addr_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_SRD: state_d = S_SWR;
      S_SWR: begin
        cmd_o.cur_we  = 1'b1;
        cmd_o.cur_sel = CUR_TARGET;
        if (last) state_d = S_RES;
        else begin
          addr_d  = addr_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_WRT: begin
        cmd_o.tgt_we   = 1'b1;
        cmd_o.tgt_load = 1'b1;
        state_d        = S_RES;
      end
      S_RDA: state_d = S_RDC;
      S_RDC: begin
        rdv_d   = cur_i;
        state_d = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.is_enabled   = en_q;
          out_d.is_disabling = dis_q;
          out_d.read_value   = rdv_q;
          out_d.stepped      = stepped_q;
          out_d.disable_done = done_q;
          out_d.status       = bad_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      addr_q      <= '0;
      cnt_q       <= '0;
      en_q        <= 1'b0;
      dis_q       <= 1'b0;
      clr_cur_q   <= 1'b0;
      clr_tgt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      cnt_q       <= cnt_d;
      en_q        <= en_d;
      dis_q       <= dis_d;
      clr_cur_q   <= clr_cur_d;
      clr_tgt_q   <= clr_tgt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    stepped_q <= stepped_d;
    done_q    <= done_d;
    bad_q     <= bad_d;
    rdv_q     <= rdv_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign addr_o      = addr_q;
  assign value_o     = value_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_q && dis_q))
    else $error("enabled and disabling both set");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q <= LAST)
    else $error("channel address beyond store");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VDIV) |-> (cnt_q < 5'(DIV_STEPS)))
    else $error("divider ran past its quotient bits");

  a_result_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && out_valid_q && !out_ready_i) |=> (state_q == S_RES))
    else $error("result overwrote an untaken result");

endmodule

/* design/synchronized_force_slew_limiter_core.sv */
// Channel  Dir  Signals                  Moves
// s_axis   in   tvalid/tready/tdata/tuser one request: mode, axis, channel, value
// m_axis   out  tvalid/tready/tdata      one result per request
// apb      in   psel/penable/pwrite/...  max_rate at 0x0, near_zero at 0x4
//
// Per request (N = channel count, 268 by default): write target and read touch
// one channel; enable/disable/reset sweep the stores once. A tick tests all N
// for near zero while disabling (if all are, it clears current and ends the
// disable), else finds the largest step, then snaps each channel or scales it
// by the shift-subtract divider. Reset clears both stores before any request.
// One request is in work at a time; a new one is taken while a result waits.
module synchronized_force_slew_limiter_core import sfsl_pkg::*; #(
  parameter int X_CHANNELS = 12,
  parameter int Y_CHANNELS = 100,
  parameter int Z_CHANNELS = 156
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // axis[1:0], channel[9:2], value[41:10], zero
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // is_enabled[0], is_disabling[1], read_value[33:2], stepped[34],
  // disable_done[35], status[36], zero
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Depth = X_CHANNELS + Y_CHANNELS + Z_CHANNELS;
  localparam int AddrW = $clog2(Depth);

  logic [30:0]      max_rate_q, near_zero_q;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [AddrW-1:0] addr;
  logic [31:0]      wr_value;
  logic [31:0]      cur_rd;
  result_t          res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q  <= 31'd3840000;
      near_zero_q <= 31'd2560;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) near_zero_q <= pwdata[30:0];
      else max_rate_q <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {1'b0, paddr[2] ? near_zero_q : max_rate_q};

  sfsl_ctrl #(
    .XCh   (X_CHANNELS),
    .YCh   (Y_CHANNELS),
    .ZCh   (Z_CHANNELS),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .axis_i      (s_axis_tdata[1:0]),
    .channel_i   (s_axis_tdata[9:2]),
    .value_i     (s_axis_tdata[41:10]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .value_o     (wr_value),
    .stat_i      (stat),
    .cur_i       (cur_rd)
  );

  sfsl_dpath #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .value_i     (wr_value),
    .max_rate_i  (max_rate_q),
    .near_zero_i (near_zero_q),
    .stat_o      (stat),
    .cur_o       (cur_rd)
  );

  assign m_axis_tdata = {3'b000, res};

endmodule
